// ----- hdl/rcfh_pkg.sv -----
// Package: shared constants, payload and command types for the rectifier CAN frame handler.
`default_nettype none

package rcfh_pkg;

  localparam int MAX_UNITS       = 8;
  localparam int IDX_W           = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int CNT_W           = $clog2(MAX_UNITS + 1);
  localparam int CMD_QUEUE_DEPTH = 2;

  localparam logic [31:0] LOGIN_INTERVAL_RESET = 32'd10000;

  localparam logic [28:0] ID_INTRO_MASK  = 29'h1FFF0000;
  localparam logic [28:0] ID_INTRO_VAL   = 29'h05000000;
  localparam logic [28:0] ID_STATUS_MASK = 29'h1F00FF00;
  localparam logic [28:0] ID_STATUS_VAL  = 29'h05004000;
  localparam logic [28:0] ID_LOGIN_BASE  = 29'h05004800;
  localparam logic [7:0]  INTRO_TAG      = 8'h1B;
  localparam logic [3:0]  FRAME_LEN      = 4'd8;

  localparam logic [7:0] CODE_NORMAL    = 8'h04;
  localparam logic [7:0] CODE_CUR_LIMIT = 8'h08;
  localparam logic [7:0] CODE_WALK_IN   = 8'h10;
  localparam logic [7:0] CODE_ALARM     = 8'h0C;

  typedef enum logic [1:0] {
    KIND_LOGIN   = 2'd0,
    KIND_STATUS  = 2'd1,
    KIND_FULL    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_NORMAL    = 3'd0,
    STAT_CUR_LIMIT = 3'd1,
    STAT_WALK_IN   = 3'd2,
    STAT_ALARM     = 3'd3,
    STAT_UNKNOWN   = 3'd4
  } unit_status_t;

  typedef struct packed {
    logic [28:0] rx_id;
    logic        remote_request;
    logic [3:0]  rx_length;
    logic [63:0] rx_data;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  unit_number;
    logic [28:0] send_id;
    logic [63:0] send_data;
    logic [2:0]  unit_status;
    logic [7:0]  temp_in;
    logic [7:0]  temp_out;
    logic [15:0] vin;
    logic [15:0] iout;
    logic [15:0] vout;
  } out_t;

  typedef struct packed {
    logic        intro;
    logic [47:0] serial;
    logic [31:0] time_ms;
    logic [7:0]  unit;
    logic [2:0]  status;
    logic [7:0]  temp_in;
    logic [7:0]  temp_out;
    logic [15:0] vin;
    logic [15:0] iout;
    logic [15:0] vout;
  } cmd_t;

  function automatic logic [2:0] decode_status(input logic [7:0] code);
    logic [2:0] st;
    unique case (code)
      CODE_NORMAL:    st = STAT_NORMAL;
      CODE_CUR_LIMIT: st = STAT_CUR_LIMIT;
      CODE_WALK_IN:   st = STAT_WALK_IN;
      CODE_ALARM:     st = STAT_ALARM;
      default:        st = STAT_UNKNOWN;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rcfh_front.sv -----
// Front end: accepts received frames, classifies them and builds commands for the back end.
`default_nettype none

module rcfh_front (
  input  wire rcfh_pkg::in_t  in_data,
  input  wire logic           push,
  output logic                full,
  output logic                q_wr,
  output rcfh_pkg::cmd_t      q_data,
  input  wire logic           q_full
);
  import rcfh_pkg::*;

  logic base_ok;
  logic intro_id;
  logic status_id;
  logic is_intro;
  logic is_status;

  always_comb begin
    base_ok   = !in_data.remote_request && (in_data.rx_length == FRAME_LEN);
    intro_id  = (in_data.rx_id & ID_INTRO_MASK) == ID_INTRO_VAL;
    status_id = (in_data.rx_id & ID_STATUS_MASK) == ID_STATUS_VAL;
    is_intro  = base_ok && intro_id && (in_data.rx_data[7:0] == INTRO_TAG);
    is_status = base_ok && !intro_id && status_id;
  end

  always_comb begin
    q_data.intro    = is_intro;
    q_data.serial   = in_data.rx_data[55:8];
    q_data.time_ms  = in_data.time_ms;
    q_data.unit     = in_data.rx_id[23:16];
    q_data.status   = decode_status(in_data.rx_id[7:0]);
    q_data.temp_in  = in_data.rx_data[7:0];
    q_data.temp_out = in_data.rx_data[63:56];
    q_data.vin      = in_data.rx_data[55:40];
    q_data.iout     = in_data.rx_data[23:8];
    q_data.vout     = in_data.rx_data[39:24];
  end

  assign full = q_full;
  assign q_wr = push && !q_full && (is_intro || is_status);

endmodule

`default_nettype wire

// ----- hdl/rcfh_cmd_queue.sv -----
// Command queue: short first-in first-out buffer between the front end and the back end.
`default_nettype none

module rcfh_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr,
  input  wire rcfh_pkg::cmd_t wr_data,
  output logic                full,
  input  wire logic           rd,
  output rcfh_pkg::cmd_t      rd_data,
  output logic                valid
);
  import rcfh_pkg::*;

  localparam int QPTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t               mem [CMD_QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_wr;
  logic               do_rd;

  assign full    = count_r == QCNT_W'(CMD_QUEUE_DEPTH);
  assign valid   = count_r != '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && valid;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rcfh_back.sv -----
// Back end: unit table search, login throttling, status checks and the result register.
`default_nettype none

module rcfh_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_wdata,
  input  wire logic           cmd_valid,
  input  wire rcfh_pkg::cmd_t cmd,
  output logic                cmd_pop,
  input  wire logic           out_pop,
  output logic                out_empty,
  output rcfh_pkg::out_t      out_data
);
  import rcfh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DECIDE
  } state_t;

  state_t                state_r;
  cmd_t                  cmd_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  hit_r;
  logic [CNT_W-1:0]      unit_count_r;
  logic [MAX_UNITS-1:0]  login_sent_r;
  logic [31:0]           interval_r;
  out_t                  out_r;
  logic                  out_valid_r;

  logic [47:0]           unit_serial_m [MAX_UNITS];
  logic [31:0]           last_time_m [MAX_UNITS];
  logic [47:0]           rd_serial_r;
  logic [31:0]           rd_time_r;

  logic                  room;
  logic [IDX_W-1:0]      new_idx;
  logic [IDX_W-1:0]      login_idx;
  logic [31:0]           elapsed;
  logic                  login_ok;
  logic [7:0]            login_unit;
  logic                  is_last;
  logic                  wr_en;
  logic                  unit_known;
  logic                  out_free;
  logic                  out_load;
  out_t                  login_res;
  out_t                  full_res;
  out_t                  status_res;

  always_comb begin
    out_free   = !out_valid_r || out_pop;
    room       = unit_count_r < CNT_W'(MAX_UNITS);
    new_idx    = unit_count_r[IDX_W-1:0];
    elapsed    = cmd_r.time_ms - rd_time_r;
    login_ok   = hit_r ? (!login_sent_r[idx_r] || (elapsed > interval_r)) : room;
    login_idx  = hit_r ? idx_r : new_idx;
    login_unit = 8'(login_idx) + 8'd1;
    is_last    = (CNT_W'(idx_r) + 1'b1) == unit_count_r;
    wr_en      = (state_r == S_DECIDE) && out_free && login_ok;
    unit_known = (cmd.unit != 8'd0) && (cmd.unit <= 8'(unit_count_r));
    cmd_pop    = (state_r == S_IDLE) && cmd_valid && out_free;
    out_load   = (cmd_pop && !cmd.intro) ||
                 ((state_r == S_DECIDE) && out_free && (login_ok || !hit_r));

    login_res             = '0;
    login_res.result_kind = KIND_LOGIN;
    login_res.unit_number = login_unit;
    login_res.send_id     = ID_LOGIN_BASE | 29'({login_unit, 2'b00});
    login_res.send_data   = {16'h0000, cmd_r.serial};

    full_res             = '0;
    full_res.result_kind = KIND_FULL;

    status_res             = '0;
    status_res.unit_number = cmd.unit;
    if (unit_known) begin
      status_res.result_kind = KIND_STATUS;
      status_res.unit_status = cmd.status;
      status_res.temp_in     = cmd.temp_in;
      status_res.temp_out    = cmd.temp_out;
      status_res.vin         = cmd.vin;
      status_res.iout        = cmd.iout;
      status_res.vout        = cmd.vout;
    end else begin
      status_res.result_kind = KIND_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unit_serial_m[login_idx] <= cmd_r.serial;
      last_time_m[login_idx]   <= cmd_r.time_ms;
    end
    rd_serial_r <= unit_serial_m[idx_r];
    rd_time_r   <= last_time_m[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cmd_r        <= '0;
      idx_r        <= '0;
      hit_r        <= 1'b0;
      unit_count_r <= '0;
      login_sent_r <= '0;
      interval_r   <= LOGIN_INTERVAL_RESET;
      out_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            cmd_r <= cmd;
            idx_r <= '0;
            hit_r <= 1'b0;
            if (cmd.intro) begin
              state_r <= (unit_count_r == '0) ? S_DECIDE : S_READ;
            end else begin
              out_r <= status_res;
            end
          end
        end
        S_READ: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (rd_serial_r == cmd_r.serial) begin
            hit_r   <= 1'b1;
            state_r <= S_DECIDE;
          end else if (is_last) begin
            state_r <= S_DECIDE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            state_r <= S_IDLE;
            if (login_ok) begin
              login_sent_r[login_idx] <= 1'b1;
              out_r                   <= login_res;
              if (!hit_r) begin
                unit_count_r <= unit_count_r + 1'b1;
              end
            end else if (!hit_r) begin
              out_r <= full_res;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    unit_count_r <= CNT_W'(MAX_UNITS))
    else $error("unit count above table size");

  a_search_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (CNT_W'(idx_r) < unit_count_r))
    else $error("search index outside filled table");

  a_login_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.result_kind == KIND_LOGIN) |->
      (out_r.unit_number != 8'd0 && out_r.unit_number <= 8'(unit_count_r)))
    else $error("login result names a unit outside the table");

  a_new_unit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && out_free && login_ok && !hit_r) |=>
      login_sent_r[$past(new_idx)])
    else $error("appended unit not marked as logged in");

endmodule

`default_nettype wire

// ----- hdl/rectifier_can_frame_handler_top.sv -----
// Top level: rectifier CAN frame handler with front end, command queue and back end.
// A status frame's result passes through the command queue, then the result register; an
// introduction loops S_READ/S_CMP per table entry compared (at most 8), then S_DECIDE.
// The back end holds one command at a time and pops the next only when the result register
// is free; the command queue accepts transactions while it has room.
// Reset clears the unit count, login flags and queues and loads the interval with 10000.
`default_nettype none

module rectifier_can_frame_handler_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                full,
  input  wire rcfh_pkg::in_t  in_data,
  input  wire logic           pop,
  output logic                empty,
  output rcfh_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_wdata
);
  import rcfh_pkg::*;

  logic q_wr;
  cmd_t q_wr_data;
  logic q_full;
  logic q_rd;
  cmd_t q_rd_data;
  logic q_valid;

  rcfh_front u_front (
    .in_data (in_data),
    .push    (push),
    .full    (full),
    .q_wr    (q_wr),
    .q_data  (q_wr_data),
    .q_full  (q_full)
  );

  rcfh_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .valid   (q_valid)
  );

  rcfh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (q_valid),
    .cmd       (q_rd_data),
    .cmd_pop   (q_rd),
    .out_pop   (pop),
    .out_empty (empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- verif/rectifier_can_frame_handler_top_tb.sv -----
// Self-checking testbench for the rectifier CAN frame handler: directed and random frames.
`default_nettype none

module rectifier_can_frame_handler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcfh_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int NUM_SERIALS     = 12;
  localparam int ITEMS_PER_PHASE = 310;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_t         in_data = '0;
  logic        pop = 1'b0;
  logic        empty;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  logic [31:0] interval_ms;
  int          units_known;
  logic [47:0] unit_serials [MAX_UNITS];
  bit          logged_in [MAX_UNITS];
  logic [31:0] login_stamp [MAX_UNITS];
  out_t        expected_responses [$];

  logic [47:0] serial_pool [NUM_SERIALS];
  logic [31:0] now_ms;
  int          errors = 0;
  bit          idle_on = 1'b1;
  bit          push_high = 1'b0;
  int          pop_hold = 0;
  int          quiet_cycles = 0;

  always #2 clk = ~clk;

  rectifier_can_frame_handler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic void predict_response(in_t f);
    out_t        r;
    logic [47:0] ser;
    logic [31:0] elapsed;
    logic [7:0]  unit;
    int          slot;
    int          k;
    r = '0;
    slot = -1;
    if (f.remote_request || f.rx_length != FRAME_LEN) return;
    if ((f.rx_id & ID_INTRO_MASK) == ID_INTRO_VAL) begin
      if (f.rx_data[7:0] != INTRO_TAG) return;
      ser = f.rx_data[55:8];
      for (k = 0; k < units_known; k++) begin
        if (slot < 0 && unit_serials[k] == ser) slot = k;
      end
      if (slot < 0) begin
        if (units_known >= MAX_UNITS) begin
          r.result_kind = KIND_FULL;
          expected_responses.push_back(r);
          return;
        end
        slot = units_known;
        units_known++;
        unit_serials[slot] = ser;
        logged_in[slot] = 1'b0;
        login_stamp[slot] = '0;
      end
      elapsed = f.time_ms - login_stamp[slot];
      if (!logged_in[slot] || elapsed > interval_ms) begin
        logged_in[slot] = 1'b1;
        login_stamp[slot] = f.time_ms;
        unit = 8'(slot + 1);
        r.result_kind = KIND_LOGIN;
        r.unit_number = unit;
        r.send_id = ID_LOGIN_BASE | {19'b0, unit, 2'b00};
        r.send_data = {16'h0, ser};
        expected_responses.push_back(r);
      end
    end else if ((f.rx_id & ID_STATUS_MASK) == ID_STATUS_VAL) begin
      unit = f.rx_id[23:16];
      r.unit_number = unit;
      if (unit == 0 || unit > units_known) begin
        r.result_kind = KIND_UNKNOWN;
      end else begin
        r.result_kind = KIND_STATUS;
        case (f.rx_id[7:0])
          CODE_NORMAL:    r.unit_status = STAT_NORMAL;
          CODE_CUR_LIMIT: r.unit_status = STAT_CUR_LIMIT;
          CODE_WALK_IN:   r.unit_status = STAT_WALK_IN;
          CODE_ALARM:     r.unit_status = STAT_ALARM;
          default:        r.unit_status = STAT_UNKNOWN;
        endcase
        r.temp_in  = f.rx_data[7:0];
        r.temp_out = f.rx_data[63:56];
        r.vin      = f.rx_data[55:40];
        r.iout     = f.rx_data[23:8];
        r.vout     = f.rx_data[39:24];
      end
      expected_responses.push_back(r);
    end
  endfunction

  function automatic in_t intro_frame(logic [47:0] ser, logic [31:0] t);
    in_t f;
    f.rx_id = ID_INTRO_VAL | 29'($urandom_range(0, 16'hFFFF));
    f.remote_request = 1'b0;
    f.rx_length = FRAME_LEN;
    f.rx_data = {8'($urandom), ser, INTRO_TAG};
    f.time_ms = t;
    return f;
  endfunction

  function automatic in_t status_frame(logic [7:0] unit, logic [7:0] code, logic [63:0] d,
                                       logic [31:0] t);
    in_t f;
    f.rx_id = ID_STATUS_VAL | (29'(unit) << 16) | 29'(code);
    f.remote_request = 1'b0;
    f.rx_length = FRAME_LEN;
    f.rx_data = d;
    f.time_ms = t;
    return f;
  endfunction

  function automatic logic [7:0] random_code();
    case ($urandom_range(0, 4))
      0:       return CODE_NORMAL;
      1:       return CODE_CUR_LIMIT;
      2:       return CODE_WALK_IN;
      3:       return CODE_ALARM;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_t random_frame();
    in_t         f;
    int          pick;
    int          k;
    logic [7:0]  unit;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) now_ms += $urandom;
    else now_ms += $urandom_range(0, 400);
    unit = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, MAX_UNITS + 1));
    if (pick < 30) begin
      k = ($urandom_range(0, 4) == 0) ? $urandom_range(MAX_UNITS, NUM_SERIALS - 1)
                                      : $urandom_range(0, MAX_UNITS - 1);
      f = intro_frame(serial_pool[k], now_ms);
    end else if (pick < 40 && units_known > 0) begin
      // Land right around the end of the login hold-off for a known unit.
      k = $urandom_range(0, units_known - 1);
      f = intro_frame(unit_serials[k], login_stamp[k] + interval_ms - 1 + $urandom_range(0, 2));
    end else if (pick < 70) begin
      f = status_frame(unit, random_code(), {$urandom, $urandom}, now_ms);
    end else if (pick < 80) begin
      if ($urandom_range(0, 1) == 1)
        f = intro_frame(serial_pool[$urandom_range(0, NUM_SERIALS - 1)], now_ms);
      else
        f = status_frame(unit, random_code(), {$urandom, $urandom}, now_ms);
      case ($urandom_range(0, 2))
        0: f.remote_request = 1'b1;
        1: f.rx_length = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, 7))
                                                       : 4'($urandom_range(9, 15));
        default: f.rx_data[7:0] = INTRO_TAG ^ 8'($urandom_range(1, 255));
      endcase
    end else begin
      f.rx_id = 29'($urandom);
      f.remote_request = 1'($urandom);
      f.rx_length = 4'($urandom_range(0, 15));
      f.rx_data = {$urandom, $urandom};
      f.time_ms = $urandom;
    end
    return f;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_response(out_t got);
    out_t want;
    if (expected_responses.size() == 0) begin
      $error("result transaction with no expectation waiting: %0h", got);
      errors++;
      return;
    end
    want = expected_responses.pop_front();
    check_field("result_kind", want.result_kind, got.result_kind);
    check_field("unit_number", want.unit_number, got.unit_number);
    check_field("send_id", want.send_id, got.send_id);
    check_field("send_data", want.send_data, got.send_data);
    check_field("unit_status", want.unit_status, got.unit_status);
    check_field("temp_in", want.temp_in, got.temp_in);
    check_field("temp_out", want.temp_out, got.temp_out);
    check_field("vin", want.vin, got.vin);
    check_field("iout", want.iout, got.iout);
    check_field("vout", want.vout, got.vout);
  endtask

  task automatic send_frame(in_t f);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      if (push_high) begin
        push <= 1'b0;
        push_high = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    push_high = 1'b1;
    in_data <= f;
    do @(posedge clk); while (full);
    predict_response(f);
  endtask

  task automatic drain_results();
    if (push_high) begin
      push <= 1'b0;
      push_high = 1'b0;
    end
    do @(posedge clk); while (expected_responses.size() != 0);
  endtask

  task automatic write_interval(logic [31:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    interval_ms = value;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        check_response(out_data);
        pop_hold = idle_on ? $urandom_range(0, 3) : 0;
      end else if (pop_hold > 0) begin
        pop_hold--;
      end
      pop <= (pop_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_ignored_frames();
    in_t f;
    f = intro_frame(serial_pool[9], now_ms);
    f.remote_request = 1'b1;
    send_frame(f);
    f = status_frame(8'd0, CODE_NORMAL, {$urandom, $urandom}, now_ms);
    f.rx_length = 4'd7;
    send_frame(f);
    f = intro_frame(serial_pool[9], now_ms);
    f.rx_length = 4'd9;
    send_frame(f);
    f = status_frame(8'd1, CODE_ALARM, '1, now_ms);
    f.rx_length = 4'd15;
    send_frame(f);
    f = status_frame(8'd1, CODE_ALARM, '0, '1);
    f.rx_length = 4'd0;
    send_frame(f);
    f = intro_frame(serial_pool[9], now_ms);
    f.rx_data[7:0] = 8'h1A;
    send_frame(f);
  endtask

  task automatic test_unknown_units();
    send_frame(status_frame(8'd0, CODE_NORMAL, {$urandom, $urandom}, now_ms));
    send_frame(status_frame(8'd1, CODE_WALK_IN, {$urandom, $urandom}, now_ms));
    send_frame(status_frame(8'hFF, 8'($urandom), {$urandom, $urandom}, now_ms));
  endtask

  task automatic test_introductions();
    in_t f;
    send_frame(intro_frame(serial_pool[0], 32'd1000));
    send_frame(intro_frame(serial_pool[0], 32'd1000));
    send_frame(intro_frame(serial_pool[0], 32'd11000));
    send_frame(intro_frame(serial_pool[0], 32'd11001));
    // Matches the status pattern as well; the introduction must win.
    f = intro_frame(serial_pool[1], 32'hFFFF_FFF0);
    f.rx_id[15:0] = {8'h40, CODE_NORMAL};
    send_frame(f);
    // Elapsed time wraps through zero and ends one past the interval.
    send_frame(intro_frame(serial_pool[1], 32'd9985));
    send_frame(status_frame(8'd3, CODE_NORMAL, {$urandom, $urandom}, now_ms));
  endtask

  task automatic test_table_full();
    int k;
    for (k = 2; k < MAX_UNITS; k++) send_frame(intro_frame(serial_pool[k], $urandom));
    send_frame(intro_frame(serial_pool[MAX_UNITS], $urandom));
  endtask

  task automatic test_status_decode();
    send_frame(status_frame(8'd1, CODE_NORMAL, '0, now_ms));
    send_frame(status_frame(8'd8, CODE_CUR_LIMIT, '1, now_ms));
    send_frame(status_frame(8'd4, CODE_WALK_IN, {$urandom, $urandom}, now_ms));
    send_frame(status_frame(8'd5, CODE_ALARM, {$urandom, $urandom}, now_ms));
    send_frame(status_frame(8'd2, 8'hFF, {$urandom, $urandom}, now_ms));
  endtask

  task automatic run_random_phase(logic [31:0] interval, bit pause_midway);
    in_t f;
    int  sent;
    bit  paused;
    sent = 0;
    paused = 1'b0;
    write_interval(interval);
    while (sent < ITEMS_PER_PHASE) begin
      if (sent % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (pause_midway && !paused && sent == ITEMS_PER_PHASE / 2) begin
        drain_results();
        paused = 1'b1;
      end
      f = random_frame();
      send_frame(f);
      sent++;
    end
  endtask

  task automatic test_interval_sweep();
    run_random_phase(32'd0, 1'b0);
    run_random_phase(32'hFFFF_FFFF, 1'b0);
    run_random_phase(32'd1, 1'b0);
    run_random_phase(32'd500, 1'b1);
    run_random_phase(32'($urandom_range(0, 20000)), 1'b0);
    run_random_phase($urandom, 1'b0);
  endtask

  initial begin
    int k;
    serial_pool[0] = '0;
    serial_pool[1] = '1;
    for (k = 2; k < NUM_SERIALS; k++) serial_pool[k] = {8'(k), $urandom, 8'($urandom)};
    interval_ms = LOGIN_INTERVAL_RESET;
    units_known = 0;
    for (k = 0; k < MAX_UNITS; k++) begin
      logged_in[k] = 1'b0;
      login_stamp[k] = '0;
    end
    now_ms = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ignored_frames();
    test_unknown_units();
    test_introductions();
    test_table_full();
    test_status_decode();
    test_interval_sweep();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_responses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/rcfh_pkg.sv
hdl/rcfh_front.sv
hdl/rcfh_cmd_queue.sv
hdl/rcfh_back.sv
hdl/rectifier_can_frame_handler_top.sv
verif/rectifier_can_frame_handler_top_tb.sv
